[hdl/tet_pkg.sv]
// Shared types, constants and the sine table for the trapezoid edge table.
`timescale 1ns / 1ps

package tet_pkg;

    // Rows at or above this count give an empty span.
    localparam int ROW_COUNT = 225;
    localparam logic [8:0] ROW_LIMIT = 9'(ROW_COUNT);

    localparam int ANGLE_W = 9;
    localparam int COORD_W = 16;
    localparam int SLOPE_W = 32;
    localparam int PIX_W   = 8;

    // Restoring division: one quotient bit per cycle for a 31-bit dividend.
    localparam int DIV_STEPS = 31;

    localparam logic [SLOPE_W-1:0] SLOPE_INF = 32'h8000_0000;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [2:0] {
        REG_ANGLE_LEFT  = 3'd0,
        REG_ANGLE_RIGHT = 3'd1,
        REG_Y_TOP       = 3'd2,
        REG_Y_APEX      = 3'd3,
        REG_X_BASE      = 3'd4,
        REG_X_APEX      = 3'd5,
        REG_SPAN_WIDTH  = 3'd6
    } reg_idx_t;

    // Quarter-wave sine magnitudes, entries 0..128, Q15.
    typedef logic [14:0] sin_half_t [0:128];

    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    typedef logic [63:0] taylor_div_t [0:9];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // (a*b) >> 60 in Q60 fixed point, built from 32-bit partial products.
    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [63:0] al;
        logic [63:0] ah;
        logic [63:0] bl;
        logic [63:0] bh;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
        logic [63:0] mid;
        logic [63:0] hi;
        logic [63:0] lo;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = {32'd0, ll[63:32]} + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        hi  = hh + {32'd0, lh[63:32]} + {32'd0, hl[63:32]} + {32'd0, mid[63:32]};
        lo  = {mid[31:0], ll[31:0]};
        return {hi[59:0], lo[63:60]};
    endfunction

    // sin(i*pi/256)*32768 truncated and limited to 32767, by a Taylor series.
    function automatic logic [14:0] sine_entry(logic [7:0] i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (PI_Q60 >> 8) * {56'd0, i};
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 0; k < 10; k++)
        begin
            term = mul_q60(term, x2) / TAYLOR_DIV[k];
            if (k % 2 == 0)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        sum = sum >> 45;
        return (sum > 64'd32767) ? 15'h7FFF : sum[14:0];
    endfunction

    function automatic sin_half_t build_sin_half();
        sin_half_t tab;
        for (int i = 0; i <= 128; i++)
        begin
            tab[i] = sine_entry(8'(i));
        end
        return tab;
    endfunction

    localparam sin_half_t SIN_HALF = build_sin_half();

    // Full-circle Q15 sine; the second half is the negated first half.
    function automatic logic signed [15:0] sine_q15(logic [ANGLE_W-1:0] a);
        logic [8:0]  folded;
        logic [15:0] mag;
        folded = (a[7:0] <= 8'd128) ? {1'b0, a[7:0]} : (9'd256 - {1'b0, a[7:0]});
        mag    = {1'b0, SIN_HALF[folded[7:0]]};
        return a[8] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[hdl/tet_slope_div.sv]
// Serial slope unit: sine * 65536 / cosine for one angle, one bit per cycle.
`timescale 1ns / 1ps

module tet_slope_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [tet_pkg::ANGLE_W-1:0]     angle,
    output logic                            busy,
    output logic [tet_pkg::SLOPE_W-1:0]     slope
);
    import tet_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [SLOPE_W-1:0]      slope_reg;
    logic [SLOPE_W-1:0]      slope_next;
    logic                    neg_reg;
    logic                    zero_reg;
    logic [14:0]             den_reg;
    logic [14:0]             rem_reg;
    logic [14:0]             rem_next;
    logic [DIV_STEPS-1:0]    quo_reg;
    logic [DIV_STEPS-1:0]    quo_next;

    logic signed [15:0]      sin_val;
    logic signed [15:0]      cos_val;
    logic [15:0]             sin_abs;
    logic [15:0]             cos_abs;
    logic [15:0]             partial;
    logic [15:0]             diff;
    logic                    fits;

    always_comb
    begin
        sin_val = sine_q15(angle);
        cos_val = sine_q15(angle + 9'd128);
        sin_abs = sin_val[15] ? 16'(-sin_val) : 16'(sin_val);
        cos_abs = cos_val[15] ? 16'(-cos_val) : 16'(cos_val);
    end

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        partial  = {rem_reg, quo_reg[DIV_STEPS-1]};
        diff     = partial - {1'b0, den_reg};
        fits     = partial >= {1'b0, den_reg};
        rem_next = fits ? diff[14:0] : partial[14:0];
        quo_next = {quo_reg[DIV_STEPS-2:0], fits};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        slope_next = slope_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                if (zero_reg)
                begin
                    slope_next = SLOPE_INF;
                end
                else if (neg_reg)
                begin
                    slope_next = -{1'b0, quo_next};
                end
                else
                begin
                    slope_next = {1'b0, quo_next};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            slope_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            slope_reg <= slope_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= sin_val[15] ^ cos_val[15];
            zero_reg <= (cos_val == 16'sd0);
            den_reg  <= cos_abs[14:0];
            rem_reg  <= '0;
            quo_reg  <= {sin_abs[14:0], 16'd0};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy  = busy_reg;
    assign slope = slope_reg;

`ifndef SYNTHESIS
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && (count_reg == CNT_W'(DIV_STEPS)))
        else $error("slope unit did not start after load");

    a_slope_held: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !load |=> $stable(slope_reg))
        else $error("slope changed while the unit was idle");
`endif

endmodule

[hdl/trapezoid_edge_table.sv]
// Top level of the trapezoid edge table: registers, slope units, span pipeline.
`timescale 1ns / 1ps

//  Channel   Signals                                  Direction  Handshake
//  config    psel penable pwrite paddr pwdata prdata  in/out     APB, pready tied high
//  request   start row                                in         start & !busy
//  result    done left_edge right_edge                out        done, one cycle
//
//  A request passes through the four register stages of the span pipeline on its way to
//  its result strobe; one request may enter every cycle while busy is low.
//  A write to either angle register recomputes that edge's slope in a serial divider;
//  busy is high meanwhile and no request is accepted.
//  Reset clears all configuration registers and both slopes to zero, which is the exact
//  slope of the reset angles, so no computation pass follows reset.
//  The receiver cannot stall, so the pipeline never holds.

module trapezoid_edge_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    input  logic [7:0]                    row,
    output logic                          busy,
    output logic                          done,
    output logic [tet_pkg::PIX_W-1:0]     left_edge,
    output logic [tet_pkg::PIX_W-1:0]     right_edge
);
    import tet_pkg::*;

    // Configuration registers.
    logic [ANGLE_W-1:0] angle_left_reg;
    logic [ANGLE_W-1:0] angle_right_reg;
    logic [COORD_W-1:0] y_top_reg;
    logic [COORD_W-1:0] y_apex_reg;
    logic [COORD_W-1:0] x_base_reg;
    logic [COORD_W-1:0] x_apex_reg;
    logic [COORD_W-1:0] span_width_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;
    logic     load_left;
    logic     load_right;
    logic     busy_left;
    logic     busy_right;
    logic [SLOPE_W-1:0] slope_left;
    logic [SLOPE_W-1:0] slope_right;
    logic     accept;

    // Pipeline stage registers.
    logic               v1_reg;
    logic               empty1_reg;
    logic [14:0]        y1_reg;
    logic               v2_reg;
    logic               empty2_reg;
    logic [15:0]        pl2_reg;
    logic [15:0]        pr2_reg;
    logic               v3_reg;
    logic               empty3_reg;
    logic [15:0]        l3_reg;
    logic [15:0]        r3_reg;
    logic               done_reg;
    logic [PIX_W-1:0]   left_reg;
    logic [PIX_W-1:0]   right_reg;

    logic [15:0]        y_sum;
    logic               empty1_next;
    logic [46:0]        prod_left;
    logic [46:0]        prod_right;
    logic [15:0]        offset;
    logic [15:0]        l3_next;
    logic [15:0]        r3_next;
    logic               l_neg;
    logic               r_neg;
    logic               l_big;
    logic               r_big;
    logic [PIX_W-1:0]   left_next;
    logic [PIX_W-1:0]   right_next;

    // The configuration port: every write completes in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_left_reg  <= '0;
            angle_right_reg <= '0;
            y_top_reg       <= '0;
            y_apex_reg      <= '0;
            x_base_reg      <= '0;
            x_apex_reg      <= '0;
            span_width_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ANGLE_LEFT:  angle_left_reg  <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_RIGHT: angle_right_reg <= pwdata[ANGLE_W-1:0];
                REG_Y_TOP:       y_top_reg       <= pwdata[COORD_W-1:0];
                REG_Y_APEX:      y_apex_reg      <= pwdata[COORD_W-1:0];
                REG_X_BASE:      x_base_reg      <= pwdata[COORD_W-1:0];
                REG_X_APEX:      x_apex_reg      <= pwdata[COORD_W-1:0];
                REG_SPAN_WIDTH:  span_width_reg  <= pwdata[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ANGLE_LEFT:  prdata = {23'd0, angle_left_reg};
            REG_ANGLE_RIGHT: prdata = {23'd0, angle_right_reg};
            REG_Y_TOP:       prdata = {16'd0, y_top_reg};
            REG_Y_APEX:      prdata = {16'd0, y_apex_reg};
            REG_X_BASE:      prdata = {16'd0, x_base_reg};
            REG_X_APEX:      prdata = {16'd0, x_apex_reg};
            REG_SPAN_WIDTH:  prdata = {16'd0, span_width_reg};
            default:         prdata = '0;
        endcase
    end

    // Each angle has its own slope unit, loaded straight from the write data so
    // that the division starts in the cycle of the write.
    assign load_left  = cfg_write && (cfg_idx == REG_ANGLE_LEFT);
    assign load_right = cfg_write && (cfg_idx == REG_ANGLE_RIGHT);

    tet_slope_div u_slope_left (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_left),
        .angle (pwdata[ANGLE_W-1:0]),
        .busy  (busy_left),
        .slope (slope_left)
    );

    tet_slope_div u_slope_right (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_right),
        .angle (pwdata[ANGLE_W-1:0]),
        .busy  (busy_right),
        .slope (slope_right)
    );

    assign busy   = busy_left || busy_right;
    assign accept = start && !busy;

    // Stage 1: the row's y and the empty-row test. A row past the table or a
    // negative y gives the empty span.
    always_comb
    begin
        y_sum       = y_top_reg - y_apex_reg + {8'd0, row};
        empty1_next = ({1'b0, row} >= ROW_LIMIT) || y_sum[15];
    end

    // Stage 2: slope times y. Only bits 31:16 of the wrapped product matter.
    always_comb
    begin
        prod_left  = {15'd0, slope_left}  * {32'd0, y1_reg};
        prod_right = {15'd0, slope_right} * {32'd0, y1_reg};
    end

    // Stage 3: add the horizontal offset; the right edge also gets the width.
    always_comb
    begin
        offset  = x_base_reg - x_apex_reg;
        l3_next = pl2_reg + offset;
        r3_next = pr2_reg + offset + span_width_reg;
    end

    // Stage 4: clamp both edges to the screen. An empty row or both edges left of
    // the screen give the empty span; both right of it give the one-pixel-short
    // span at the right border.
    always_comb
    begin
        l_neg = l3_reg[15];
        r_neg = r3_reg[15];
        l_big = !l3_reg[15] && (l3_reg[14:8] != 7'd0);
        r_big = !r3_reg[15] && (r3_reg[14:8] != 7'd0);
        if (empty3_reg || (l_neg && r_neg))
        begin
            left_next  = 8'd1;
            right_next = 8'd0;
        end
        else if (l_big && r_big)
        begin
            left_next  = 8'd255;
            right_next = 8'd254;
        end
        else
        begin
            left_next  = l_neg ? 8'd0 : (l_big ? 8'd255 : l3_reg[7:0]);
            right_next = r_neg ? 8'd0 : (r_big ? 8'd255 : r3_reg[7:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        empty1_reg <= empty1_next;
        y1_reg     <= y_sum[14:0];
        empty2_reg <= empty1_reg;
        pl2_reg    <= prod_left[31:16];
        pr2_reg    <= prod_right[31:16];
        empty3_reg <= empty2_reg;
        l3_reg     <= l3_next;
        r3_reg     <= r3_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

    assign done       = done_reg;
    assign left_edge  = left_reg;
    assign right_edge = right_reg;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("request did not produce a result four cycles later");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result without a matching request");

    a_busy_from_angle_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(load_left || load_right))
        else $error("busy rose without an angle write");

    a_empty_span_shape: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && empty3_reg |=> done && (left_edge == 8'd1) && (right_edge == 8'd0))
        else $error("empty row did not give the empty span");
`endif

endmodule

[verif/trapezoid_edge_table_tb.sv]
// Self-checking testbench for the trapezoid edge table: directed table, then random phases.
`timescale 1ns / 1ps

module trapezoid_edge_table_tb;

    import tet_pkg::*;

    // The cycle budget is far above the slowest legal run: about 750 requests, some
    // with a short random gap, plus up to two slope recomputations per phase.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ROWS = 700;
    localparam int TAIL_CYCLES = 12;

    // Register index that is not mapped; a write to it must change nothing.
    localparam logic [2:0] IDX_UNMAPPED = 3'd7;

    // 2^60 * pi, the fixed-point base of the sine series.
    localparam logic [63:0] PI_FIXED = 64'h3243_F6A8_885A_308D;

    // Angles that sit on the axes or right next to them.
    localparam int ANGLE_CORNERS [10] = '{0, 1, 127, 128, 129, 255, 256, 383, 384, 511};

    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
    } span_t;

    typedef enum logic {
        STEP_WRITE,
        STEP_ROW
    } step_kind_t;

    // One line of the directed script. A register write uses idx and data; a row
    // request uses row, and carries a hand-written span only when fixed is set.
    typedef struct {
        step_kind_t  kind;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [7:0]  row;
        bit          fixed;
        logic [7:0]  left;
        logic [7:0]  right;
    } script_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        start = 1'b0;
    logic [7:0]  row = '0;
    logic        busy;
    logic        done;
    logic [PIX_W-1:0] left_edge;
    logic [PIX_W-1:0] right_edge;

    // Shadow copy of the configuration registers, updated at each write.
    logic [8:0]  angle_left_q = '0;
    logic [8:0]  angle_right_q = '0;
    logic [15:0] y_top_q = '0;
    logic [15:0] y_apex_q = '0;
    logic [15:0] x_base_q = '0;
    logic [15:0] x_apex_q = '0;
    logic [15:0] span_width_q = '0;

    // Magnitudes of the first half circle of the Q15 sine.
    int sine_mag [0:255];

    span_t span_queue [$];
    span_t oldest_span;
    int    mismatches = 0;
    int    cycles = 0;

    const script_step_t script [] = '{
        // Straight after reset both slopes are zero and the offset is zero.
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd0,   1'b1, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd224, 1'b1, 8'd0,   8'd0},
        // Rows past the last scanline always give the empty span.
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd225, 1'b1, 8'd1,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd255, 1'b1, 8'd1,   8'd0},
        // Both edges past the right border.
        '{STEP_WRITE, REG_X_BASE,      32'd300,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd17,  1'b1, 8'd255, 8'd254},
        // Both edges left of the border: offset of minus one.
        '{STEP_WRITE, REG_X_BASE,      32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_X_APEX,      32'd1,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd5,   1'b1, 8'd1,   8'd0},
        '{STEP_WRITE, REG_SPAN_WIDTH,  32'd100,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd5,   1'b0, 8'd0,   8'd0},
        // A start row above the top gives a negative y.
        '{STEP_WRITE, REG_Y_APEX,      32'd300,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd0,   1'b1, 8'd1,   8'd0},
        // The largest positive y, and the row after it that wraps negative.
        '{STEP_WRITE, REG_Y_TOP,       32'h0000_7FFF, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_Y_APEX,      32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd1,   1'b1, 8'd1,   8'd0},
        // Vertical edges: a zero cosine on both sides, the right one written with
        // its upper data bits set so that the width mask is exercised.
        '{STEP_WRITE, REG_Y_TOP,       32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_ANGLE_LEFT,  32'd128,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_ANGLE_RIGHT, 32'hFFFF_FF80, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd1,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd2,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd224, 1'b0, 8'd0,   8'd0},
        // Shallow slopes of opposite sign around the middle of the screen.
        '{STEP_WRITE, REG_ANGLE_LEFT,  32'd511,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_ANGLE_RIGHT, 32'd1,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_X_BASE,      32'd128,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_X_APEX,      32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_SPAN_WIDTH,  32'd0,         8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd100, 1'b0, 8'd0,   8'd0},
        // A write past the register list must leave the spans unchanged.
        '{STEP_WRITE, IDX_UNMAPPED,    32'hFFFF_FFFF, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd224, 1'b0, 8'd0,   8'd0},
        // Half-circle angle on the left, a shallow negative slope on the right,
        // and the x and width registers at their maximum.
        '{STEP_WRITE, REG_ANGLE_LEFT,  32'd256,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_ANGLE_RIGHT, 32'd255,       8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_X_BASE,      32'h0000_FFFF, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_X_APEX,      32'h0000_FFFF, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_WRITE, REG_SPAN_WIDTH,  32'h0000_FFFF, 8'd0,   1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd224, 1'b0, 8'd0,   8'd0},
        '{STEP_ROW,   IDX_UNMAPPED,    32'd0,         8'd128, 1'b0, 8'd0,   8'd0}
    };

    trapezoid_edge_table i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .row        (row),
        .busy       (busy),
        .done       (done),
        .left_edge  (left_edge),
        .right_edge (right_edge)
    );

    always #4 clk = ~clk;

    // Upper 4 bits dropped, lower 60 shifted out: the product of two Q60 numbers.
    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // sin(i*pi/256) scaled to Q15 and truncated, from an eleven-term Taylor series
    // evaluated in Q60; the peak value is limited to 32767.
    function automatic int taylor_sine(int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (PI_FIXED >> 8) * 64'(i);
        x2   = q60_mul(x, x);
        term = x;
        acc  = x;
        for (int k = 1; k <= 10; k++)
        begin
            term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        acc = acc >> 45;
        return (acc > 64'd32767) ? 32767 : int'(acc);
    endfunction

    function automatic int sine_q15(logic [8:0] angle);
        return angle[8] ? -sine_mag[angle[7:0]] : sine_mag[angle[7:0]];
    endfunction

    // tan(angle) in 16.16, truncated toward zero; a vertical edge saturates to the
    // most negative 32-bit value.
    function automatic logic [31:0] slope_of(logic [8:0] angle);
        longint s;
        longint c;
        longint q;
        s = sine_q15(angle);
        c = sine_q15(angle + 9'd128);
        if (c == 0)
        begin
            return 32'h8000_0000;
        end
        q = (s * 65536) / c;
        return 32'(q);
    endfunction

    // Integer part of slope*y, plus the horizontal offset, wrapped to 16 bits.
    function automatic int edge_at(logic [31:0] sl, logic [15:0] y, logic [31:0] add);
        logic [31:0]        prod;
        logic [31:0]        sum;
        logic signed [15:0] pos;
        prod = sl * {16'd0, y};
        sum  = {{16{prod[31]}}, prod[31:16]} + add;
        pos  = sum[15:0];
        return pos;
    endfunction

    // The span that the block must answer for one row under the shadow settings.
    function automatic span_t span_of_row(logic [7:0] r);
        span_t       s;
        logic [15:0] y;
        logic [31:0] offset;
        int          lo;
        int          hi;
        s.left  = 8'd1;
        s.right = 8'd0;
        y = y_top_q - y_apex_q + {8'd0, r};
        if (int'(r) < ROW_COUNT && !y[15])
        begin
            offset = {16'd0, x_base_q} - {16'd0, x_apex_q};
            lo = edge_at(slope_of(angle_left_q), y, offset);
            hi = edge_at(slope_of(angle_right_q), y, offset + {16'd0, span_width_q});
            if (lo < 0 && hi < 0)
            begin
                lo = 1;
                hi = 0;
            end
            else
            begin
                lo = (lo < 0) ? 0 : lo;
                hi = (hi < 0) ? 0 : hi;
            end
            if (lo > 255 && hi > 255)
            begin
                lo = 255;
                hi = 254;
            end
            else
            begin
                lo = (lo > 255) ? 255 : lo;
                hi = (hi > 255) ? 255 : hi;
            end
            s.left  = lo[7:0];
            s.right = hi[7:0];
        end
        return s;
    endfunction

    // Sometimes sets the data bits above a register's width; the block must mask them.
    function automatic logic [31:0] dirty_upper(logic [31:0] value, int width);
        logic [31:0] noise;
        noise = ($urandom_range(0, 3) == 0) ? ($urandom << width) : 32'd0;
        return value | noise;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // One APB write: setup cycle, then the access cycle that ends at the write edge.
    // psel stays high afterwards, so back-to-back writes need no idle cycle; the next
    // row request lowers it.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        case (idx)
            REG_ANGLE_LEFT:  angle_left_q  = data[8:0];
            REG_ANGLE_RIGHT: angle_right_q = data[8:0];
            REG_Y_TOP:       y_top_q       = data[15:0];
            REG_Y_APEX:      y_apex_q      = data[15:0];
            REG_X_BASE:      x_base_q      = data[15:0];
            REG_X_APEX:      x_apex_q      = data[15:0];
            REG_SPAN_WIDTH:  span_width_q  = data[15:0];
            default:         ;
        endcase
    endtask

    // Offers one row request and holds it until an edge with busy low takes it; the
    // expected span is queued at that edge, either the typed one or the predicted one.
    task automatic send_row(input logic [7:0] r, input bit fixed, input span_t typed);
        psel  <= 1'b0;
        start <= 1'b1;
        row   <= r;
        do
            @(posedge clk);
        while (busy);
        span_queue.push_back(fixed ? typed : span_of_row(r));
    endtask

    // Stops offering requests and waits until every queued span has come back.
    task automatic drain_spans();
        start <= 1'b0;
        do
            @(posedge clk);
        while (span_queue.size() != 0);
    endtask

    // Results are sampled at the edge that ends their strobe cycle, before any of the
    // block's own updates at that edge take effect.
    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (span_queue.size() == 0)
            begin
                flag_mismatch($sformatf("span (%0d,%0d) with no request pending",
                                        left_edge, right_edge));
            end
            else
            begin
                oldest_span = span_queue.pop_front();
                if (left_edge !== oldest_span.left)
                begin
                    flag_mismatch($sformatf("left_edge %0d, expected %0d",
                                            left_edge, oldest_span.left));
                end
                if (right_edge !== oldest_span.right)
                begin
                    flag_mismatch($sformatf("right_edge %0d, expected %0d",
                                            right_edge, oldest_span.right));
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("trapezoid_edge_table test failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] vals [7];
        int          phase;
        int          sent;
        int          burst;
        bit          quiet;
        span_t       typed;

        for (int i = 0; i < 256; i++)
        begin
            sine_mag[i] = taylor_sine((i <= 128) ? i : 256 - i);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed script. Every register write waits until the pipeline is empty,
        // so no request in flight ever sees a half-changed configuration.
        foreach (script[s])
        begin
            if (script[s].kind == STEP_WRITE)
            begin
                drain_spans();
                write_reg(script[s].idx, script[s].data);
            end
            else
            begin
                typed.left  = script[s].left;
                typed.right = script[s].right;
                send_row(script[s].row, script[s].fixed, typed);
            end
        end

        // Random phases. Each one drains, rewrites part of the configuration and then
        // streams a burst of rows. The first phase puts every register at its maximum
        // and the second at zero. Otherwise y_top mostly sits a little below or above
        // y_apex and the offset mostly lands near the screen, so that most rows give
        // real spans rather than the empty one.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ROWS)
        begin
            drain_spans();
            if (phase == 0)
            begin
                vals = '{16'd511, 16'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            end
            else if (phase == 1)
            begin
                vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            end
            else
            begin
                vals[0] = ($urandom_range(0, 3) == 0) ? 16'(ANGLE_CORNERS[$urandom_range(0, 9)])
                                                      : 16'($urandom_range(0, 511));
                vals[1] = ($urandom_range(0, 3) == 0) ? 16'(ANGLE_CORNERS[$urandom_range(0, 9)])
                                                      : 16'($urandom_range(0, 511));
                vals[3] = 16'($urandom);
                vals[2] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : vals[3] + 16'($urandom_range(0, 300)) - 16'd60;
                vals[4] = 16'($urandom);
                vals[5] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : vals[4] - 16'($urandom_range(0, 400)) + 16'd100;
                vals[6] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 200));
            end
            for (int r = 0; r < 7; r++)
            begin
                if (phase < 2 || $urandom_range(0, 3) != 0)
                begin
                    write_reg(3'(r), dirty_upper({16'd0, vals[r]}, (r < 2) ? ANGLE_W : COORD_W));
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(IDX_UNMAPPED, $urandom);
            end

            // Two middle phases run back to back with no gaps at all.
            quiet = (phase == 5 || phase == 6);
            burst = $urandom_range(30, 80);
            for (int j = 0; j < burst; j++)
            begin
                if (!quiet && $urandom_range(0, 99) < 8)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
                else if (!quiet && $urandom_range(0, 59) == 0)
                begin
                    drain_spans();
                end
                send_row(($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 224))
                                                      : 8'($urandom_range(225, 255)),
                         1'b0, '0);
                sent++;
            end
            phase++;
        end

        drain_spans();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("trapezoid_edge_table test passed");
        end
        else
        begin
            $display("trapezoid_edge_table test failed");
        end
        $finish;
    end

endmodule
